/* hw/rtl/lbc_pkg.sv */
// Shared constants for the 3D line/box clipper: default widths and
// configuration register indexes. No dependencies.
`default_nettype none

package lbc_pkg;

    // Default coordinate format (signed Q16.16).
    localparam int LBC_COORD_WIDTH = 32;
    localparam int LBC_FRAC_BITS   = 16;

    // Configuration register indexes.
    localparam int LBC_IDX_BITS = 3;
    localparam logic [LBC_IDX_BITS-1:0] REG_X_LOW  = 3'd0;
    localparam logic [LBC_IDX_BITS-1:0] REG_X_HIGH = 3'd1;
    localparam logic [LBC_IDX_BITS-1:0] REG_Y_LOW  = 3'd2;
    localparam logic [LBC_IDX_BITS-1:0] REG_Y_HIGH = 3'd3;
    localparam logic [LBC_IDX_BITS-1:0] REG_Z_LOW  = 3'd4;
    localparam logic [LBC_IDX_BITS-1:0] REG_Z_HIGH = 3'd5;

endpackage

`default_nettype wire

/* hw/rtl/lbc_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; used by line_box_clip_3d for the endpoint quotients.
`default_nettype none

module lbc_div #(
    parameter int DEN_W = 32,
    parameter int Q_W   = 34
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [DEN_W-1:0] i_rem,   // partial remainder, below i_den
    input  wire logic [Q_W-1:0]   i_low,   // dividend bits still to shift in
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [Q_W-1:0]   o_quo,
    output logic      [DEN_W-1:0] o_rem,
    output logic      [DEN_W-1:0] o_den
);

    logic [DEN_W-1:0] r_rem [Q_W];
    logic [Q_W-1:0]   r_low [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];

    logic [DEN_W-1:0] w_rem [Q_W];
    logic [Q_W-1:0]   w_low [Q_W];
    logic [Q_W-1:0]   w_quo [Q_W];
    logic [DEN_W-1:0] w_den [Q_W];

    logic [DEN_W-1:0] n_rem [Q_W];
    logic [Q_W-1:0]   n_low [Q_W];
    logic [Q_W-1:0]   n_quo [Q_W];

    // Stage inputs: the ports for the first stage, the previous stage after.
    always_comb begin
        for (int j = 0; j < Q_W; j++) begin
            if (j == 0) begin
                w_rem[j] = i_rem;
                w_low[j] = i_low;
                w_quo[j] = '0;
                w_den[j] = i_den;
            end else begin
                w_rem[j] = r_rem[j-1];
                w_low[j] = r_low[j-1];
                w_quo[j] = r_quo[j-1];
                w_den[j] = r_den[j-1];
            end
        end
    end

    // One trial subtraction per stage.
    always_comb begin
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;
        for (int j = 0; j < Q_W; j++) begin
            trial    = {w_rem[j], w_low[j][Q_W-1]};
            diff     = trial - {1'b0, w_den[j]};
            ge       = trial >= {1'b0, w_den[j]};
            n_rem[j] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_low[j] = {w_low[j][Q_W-2:0], 1'b0};
            n_quo[j] = {w_quo[j][Q_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < Q_W; j++) begin
                r_rem[j] <= n_rem[j];
                r_low[j] <= n_low[j];
                r_quo[j] <= n_quo[j];
                r_den[j] <= w_den[j];
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];
    assign o_rem = r_rem[Q_W-1];
    assign o_den = r_den[Q_W-1];

endmodule

`default_nettype wire

/* hw/rtl/line_box_clip_3d.sv */
// Top level of the 3D line/box slab clipper.
// Depends on lbc_pkg and on lbc_div for the six endpoint divisions.
//
// Channel  | Direction | Transaction
// ---------+-----------+----------------------------------------------
// s (in)   | slave     | one line: base point and direction
// m (out)  | master    | visible flag, entry (tail) and exit (head) points
// cfg      | write     | one box bound register per write
//
// One line enters per cycle while the output is not stalled; the pipeline depth
// is set by the one-bit-per-stage endpoint dividers.
// Reset is synchronous and clears the valid bits and the box to [0, 1.0].
// When the output register holds an untaken result the whole pipeline
// freezes, so nothing is lost or repeated.
`default_nettype none

module line_box_clip_3d
    import lbc_pkg::*;
#(
    parameter int COORD_WIDTH = LBC_COORD_WIDTH,
    parameter int FRAC_BITS   = LBC_FRAC_BITS,
    localparam int W  = COORD_WIDTH,
    localparam int IB = ((6 * W + 7) / 8) * 8,
    localparam int OB = ((6 * W + 1 + 7) / 8) * 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // i_s_tdata: base_x, base_y, base_z, dir_x, dir_y, dir_z (low bits first)
    input  wire logic                    i_s_tvalid,
    output logic                         o_s_tready,
    input  wire logic [IB-1:0]           i_s_tdata,
    // o_m_tdata: visible, tail_x, tail_y, tail_z, head_x, head_y, head_z
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    output logic      [OB-1:0]           o_m_tdata,
    input  wire logic                    i_cfg_we,
    input  wire logic [LBC_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [W-1:0]            i_cfg_data
);

    localparam int NW  = W + 2;          // signed ratio numerator
    localparam int PW  = NW + W + 1;     // cross product for ratio compares
    localparam int QB  = W + 2;          // quotient bits
    localparam int MW  = 2 * W + 1;      // |t numerator| * |dir|
    localparam int SW  = W + 4;          // signed endpoint sum
    localparam int TOT = W + 14;         // total register stages

    localparam logic signed [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

    // Box bounds.
    logic signed [W-1:0] r_lo [3];
    logic signed [W-1:0] r_hi [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= '0;
                r_hi[k] <= {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_X_LOW:  r_lo[0] <= i_cfg_data;
                REG_X_HIGH: r_hi[0] <= i_cfg_data;
                REG_Y_LOW:  r_lo[1] <= i_cfg_data;
                REG_Y_HIGH: r_hi[1] <= i_cfg_data;
                REG_Z_LOW:  r_lo[2] <= i_cfg_data;
                REG_Z_HIGH: r_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advance and valid bits.
    logic         w_en;
    logic [TOT-1:0] r_vld;

    assign w_en       = !r_vld[TOT-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[TOT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOT-2:0], i_s_tvalid};
        end
    end

    // Base and direction delay lines.
    logic [3*W-1:0] r_bd [TOT-1];
    logic [3*W-1:0] r_dd [8];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bd[0] <= i_s_tdata[3*W-1:0];
            for (int j = 1; j < TOT - 1; j++) r_bd[j] <= r_bd[j-1];
            r_dd[0] <= i_s_tdata[6*W-1:3*W];
            for (int j = 1; j < 8; j++) r_dd[j] <= r_dd[j-1];
        end
    end

    // Stage 0: slab numerators, oriented so the denominator is positive.
    logic signed [NW-1:0] r0_sa [3];
    logic signed [NW-1:0] r0_sb [3];
    logic        [W-1:0]  r0_den [3];
    logic                 r0_nz [3];
    logic                 r0_rej;

    always_ff @(posedge i_clk) begin
        logic signed [W-1:0]  base, dir;
        logic signed [NW-1:0] da, db;
        logic signed [W:0]    dabs;
        logic                 rej;
        if (w_en) begin
            rej = 1'b0;
            for (int k = 0; k < 3; k++) begin
                base = i_s_tdata[k*W +: W];
                dir  = i_s_tdata[(k+3)*W +: W];
                da   = NW'(r_hi[k]) - NW'(base);
                db   = NW'(r_lo[k]) - NW'(base);
                dabs = dir[W-1] ? -(W+1)'(dir) : (W+1)'(dir);
                r0_sa[k]  <= dir[W-1] ? -da : da;
                r0_sb[k]  <= dir[W-1] ? -db : db;
                r0_den[k] <= dabs[W-1:0];
                r0_nz[k]  <= |dir;
                if (dir == '0 && (base < r_lo[k] || base > r_hi[k])) rej = 1'b1;
            end
            r0_rej <= rej;
        end
    end

    // Stage 1: order each axis's crossings into entry and exit.
    logic signed [NW-1:0] r1_e [3];
    logic signed [NW-1:0] r1_x [3];
    logic        [W-1:0]  r1_den [3];
    logic                 r1_nz [3];
    logic                 r1_rej;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_e[k]   <= (r0_sa[k] < r0_sb[k]) ? r0_sa[k] : r0_sb[k];
                r1_x[k]   <= (r0_sa[k] < r0_sb[k]) ? r0_sb[k] : r0_sa[k];
                r1_den[k] <= r0_den[k];
                r1_nz[k]  <= r0_nz[k];
            end
            r1_rej <= r0_rej;
        end
    end

    // Stage 2: cross products comparing x against y.
    logic signed [PW-1:0] r2_pe_xy, r2_pe_yx, r2_px_xy, r2_px_yx;
    logic signed [NW-1:0] r2_e [3];
    logic signed [NW-1:0] r2_x [3];
    logic        [W-1:0]  r2_den [3];
    logic                 r2_nz [3];
    logic                 r2_rej;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_pe_xy <= r1_e[0] * $signed({1'b0, r1_den[1]});
            r2_pe_yx <= r1_e[1] * $signed({1'b0, r1_den[0]});
            r2_px_xy <= r1_x[0] * $signed({1'b0, r1_den[1]});
            r2_px_yx <= r1_x[1] * $signed({1'b0, r1_den[0]});
            for (int k = 0; k < 3; k++) begin
                r2_e[k]   <= r1_e[k];
                r2_x[k]   <= r1_x[k];
                r2_den[k] <= r1_den[k];
                r2_nz[k]  <= r1_nz[k];
            end
            r2_rej <= r1_rej;
        end
    end

    // Stage 3: latest entry and earliest exit over x and y.
    logic signed [NW-1:0] r3_in_n, r3_out_n, r3_ze, r3_zx;
    logic        [W-1:0]  r3_in_d, r3_out_d, r3_zd;
    logic                 r3_have, r3_znz, r3_rej;

    always_ff @(posedge i_clk) begin
        logic pick_y_in, pick_y_out;
        if (w_en) begin
            pick_y_in  = r2_nz[1] && (!r2_nz[0] || r2_pe_yx > r2_pe_xy);
            pick_y_out = r2_nz[1] && (!r2_nz[0] || r2_px_yx < r2_px_xy);
            r3_in_n  <= pick_y_in ? r2_e[1] : r2_e[0];
            r3_in_d  <= pick_y_in ? r2_den[1] : r2_den[0];
            r3_out_n <= pick_y_out ? r2_x[1] : r2_x[0];
            r3_out_d <= pick_y_out ? r2_den[1] : r2_den[0];
            r3_have  <= r2_nz[0] || r2_nz[1];
            r3_ze    <= r2_e[2];
            r3_zx    <= r2_x[2];
            r3_zd    <= r2_den[2];
            r3_znz   <= r2_nz[2];
            r3_rej   <= r2_rej;
        end
    end

    // Stage 4: cross products comparing the x/y result against z.
    logic signed [PW-1:0] r4_p_in, r4_pz_in, r4_p_out, r4_pz_out;
    logic signed [NW-1:0] r4_in_n, r4_out_n, r4_ze, r4_zx;
    logic        [W-1:0]  r4_in_d, r4_out_d, r4_zd;
    logic                 r4_have, r4_znz, r4_rej;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_p_in   <= r3_in_n * $signed({1'b0, r3_zd});
            r4_pz_in  <= r3_ze * $signed({1'b0, r3_in_d});
            r4_p_out  <= r3_out_n * $signed({1'b0, r3_zd});
            r4_pz_out <= r3_zx * $signed({1'b0, r3_out_d});
            r4_in_n   <= r3_in_n;
            r4_out_n  <= r3_out_n;
            r4_in_d   <= r3_in_d;
            r4_out_d  <= r3_out_d;
            r4_ze     <= r3_ze;
            r4_zx     <= r3_zx;
            r4_zd     <= r3_zd;
            r4_have   <= r3_have;
            r4_znz    <= r3_znz;
            r4_rej    <= r3_rej;
        end
    end

    // Stage 5: fold in z.
    logic signed [NW-1:0] r5_in_n, r5_out_n;
    logic        [W-1:0]  r5_in_d, r5_out_d;
    logic                 r5_have, r5_rej;

    always_ff @(posedge i_clk) begin
        logic pick_z_in, pick_z_out;
        if (w_en) begin
            pick_z_in  = r4_znz && (!r4_have || r4_pz_in > r4_p_in);
            pick_z_out = r4_znz && (!r4_have || r4_pz_out < r4_p_out);
            r5_in_n  <= pick_z_in ? r4_ze : r4_in_n;
            r5_in_d  <= pick_z_in ? r4_zd : r4_in_d;
            r5_out_n <= pick_z_out ? r4_zx : r4_out_n;
            r5_out_d <= pick_z_out ? r4_zd : r4_out_d;
            r5_have  <= r4_have || r4_znz;
            r5_rej   <= r4_rej;
        end
    end

    // Stage 6: cross products for entry < exit.
    logic signed [PW-1:0] r6_p_io, r6_p_oi;
    logic signed [NW-1:0] r6_in_n, r6_out_n;
    logic        [W-1:0]  r6_in_d, r6_out_d;
    logic                 r6_have, r6_rej;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_p_io  <= r5_in_n * $signed({1'b0, r5_out_d});
            r6_p_oi  <= r5_out_n * $signed({1'b0, r5_in_d});
            r6_in_n  <= r5_in_n;
            r6_out_n <= r5_out_n;
            r6_in_d  <= r5_in_d;
            r6_out_d <= r5_out_d;
            r6_have  <= r5_have;
            r6_rej   <= r5_rej;
        end
    end

    // Stage 7: visibility decision; split entry and exit into sign and size.
    logic         r7_vis;
    logic         r7_neg [2];
    logic [W:0]   r7_mag [2];
    logic [W-1:0] r7_den [2];

    always_ff @(posedge i_clk) begin
        logic signed [NW-1:0] abs_in, abs_out;
        if (w_en) begin
            abs_in  = r6_in_n[NW-1] ? -r6_in_n : r6_in_n;
            abs_out = r6_out_n[NW-1] ? -r6_out_n : r6_out_n;
            r7_vis    <= r6_have && !r6_rej && (r6_p_io < r6_p_oi);
            r7_neg[0] <= r6_in_n[NW-1];
            r7_neg[1] <= r6_out_n[NW-1];
            r7_mag[0] <= abs_in[W:0];
            r7_mag[1] <= abs_out[W:0];
            r7_den[0] <= r6_in_d;
            r7_den[1] <= r6_out_d;
        end
    end

    // Stage 8: endpoint offset numerators |t num| * |dir|, entries 0..2 tail.
    logic [MW-1:0] r8_p [6];
    logic [5:0]    r8_neg;
    logic [W-1:0]  r8_den [2];
    logic          r8_vis;

    always_ff @(posedge i_clk) begin
        logic signed [W-1:0] dir;
        logic        [W:0]   dabs;
        if (w_en) begin
            for (int g = 0; g < 6; g++) begin
                dir       = r_dd[7][(g % 3)*W +: W];
                dabs      = dir[W-1] ? -(W+1)'(dir) : (W+1)'(dir);
                r8_p[g]   <= r7_mag[g / 3] * dabs[W-1:0];
                r8_neg[g] <= r7_neg[g / 3] ^ dir[W-1];
            end
            r8_den[0] <= r7_den[0];
            r8_den[1] <= r7_den[1];
            r8_vis    <= r7_vis;
        end
    end

    // Stage 9: overflow check on the quotient and divider setup.
    logic [W-1:0]  r9_rem [6];
    logic [QB-1:0] r9_low [6];
    logic [W-1:0]  r9_den [6];
    logic [5:0]    r9_ovf;
    logic [5:0]    r9_neg;
    logic          r9_vis;

    always_ff @(posedge i_clk) begin
        logic [W-1:0] top;
        logic         ovf;
        if (w_en) begin
            for (int g = 0; g < 6; g++) begin
                top       = {1'b0, r8_p[g][MW-1:QB]};
                ovf       = top >= r8_den[g / 3];
                r9_ovf[g] <= ovf;
                r9_rem[g] <= ovf ? '0 : top;
                r9_low[g] <= r8_p[g][QB-1:0];
                r9_den[g] <= r8_den[g / 3];
            end
            r9_neg <= r8_neg;
            r9_vis <= r8_vis;
        end
    end

    // Endpoint dividers.
    logic [QB-1:0] w_quo [6];
    logic [W-1:0]  w_rem [6];
    logic [W-1:0]  w_den [6];

    for (genvar g = 0; g < 6; g++) begin : g_div
        lbc_div #(
            .DEN_W (W),
            .Q_W   (QB)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (r9_rem[g]),
            .i_low (r9_low[g]),
            .i_den (r9_den[g]),
            .o_quo (w_quo[g]),
            .o_rem (w_rem[g]),
            .o_den (w_den[g])
        );
    end

    // Flags travel alongside the dividers.
    logic [5:0] r_dl_ovf [QB];
    logic [5:0] r_dl_neg [QB];
    logic       r_dl_vis [QB];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl_ovf[0] <= r9_ovf;
            r_dl_neg[0] <= r9_neg;
            r_dl_vis[0] <= r9_vis;
            for (int j = 1; j < QB; j++) begin
                r_dl_ovf[j] <= r_dl_ovf[j-1];
                r_dl_neg[j] <= r_dl_neg[j-1];
                r_dl_vis[j] <= r_dl_vis[j-1];
            end
        end
    end

    // Rounding stage: nearest, ties away from zero, then apply the sign.
    logic signed [SW-1:0] rr_q [6];
    logic [5:0]           rr_ovf;
    logic [5:0]           rr_neg;
    logic                 rr_vis;

    always_ff @(posedge i_clk) begin
        logic [W+2:0] qm;
        if (w_en) begin
            for (int g = 0; g < 6; g++) begin
                qm = {1'b0, w_quo[g]}
                   + (W+3)'({w_rem[g], 1'b0} >= {1'b0, w_den[g]});
                rr_q[g] <= r_dl_neg[QB-1][g] ? -SW'(qm) : SW'(qm);
            end
            rr_ovf <= r_dl_ovf[QB-1];
            rr_neg <= r_dl_neg[QB-1];
            rr_vis <= r_dl_vis[QB-1];
        end
    end

    // Output register: add the base point and saturate.
    logic [OB-1:0] r_out;

    always_ff @(posedge i_clk) begin
        logic signed [SW-1:0] sum, sat;
        logic signed [W-1:0]  base;
        logic        [OB-1:0] word;
        if (w_en) begin
            word    = '0;
            word[0] = rr_vis;
            for (int g = 0; g < 6; g++) begin
                base = r_bd[TOT-2][(g % 3)*W +: W];
                sum  = SW'(base) + rr_q[g];
                if (rr_ovf[g])     sat = rr_neg[g] ? SMIN : SMAX;
                else if (sum > SMAX) sat = SMAX;
                else if (sum < SMIN) sat = SMIN;
                else                 sat = sum;
                word[1 + g*W +: W] = rr_vis ? sat[W-1:0] : '0;
            end
            r_out <= word;
        end
    end

    assign o_m_tdata = r_out;

    // A hidden line carries all-zero endpoints.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[6*W:1] == '0)
        else $error("hidden line with nonzero endpoints");

    // Reset empties the pipeline.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // An empty output register never blocks the input.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // An accepted transaction enters the first stage.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_vld[0])
        else $error("accepted transaction lost at entry");

endmodule

`default_nettype wire
